// File: design/sfr_pkg.sv
package sfr_pkg;

  localparam int unsigned TimerBitsDef  = 20;
  localparam int unsigned QueueDepthDef = 4;
  localparam int unsigned CfgW          = 20;
  localparam int unsigned SpeedW        = 20;
  localparam int unsigned ScaledW       = SpeedW + 4;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_DETECT = 2'd1,
    PH_NORMAL = 2'd2,
    PH_FLING  = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    RP_DRAW_START  = 3'd0,
    RP_DRAW_STOP   = 3'd1,
    RP_SLIDE_BEGIN = 3'd2,
    RP_SLIDE_END   = 3'd3,
    RP_FLING_ON    = 3'd4,
    RP_FLING_OFF   = 3'd5,
    RP_NONE        = 3'd6
  } report_t;

  typedef enum logic [3:0] {
    K_TICK      = 4'd0,
    K_DETECT    = 4'd1,
    K_FLING_ON  = 4'd2,
    K_SLIDE_OFF = 4'd3,
    K_FRAME     = 4'd4,
    K_DOWN      = 4'd5,
    K_UP        = 4'd6,
    K_PULL_UP   = 4'd7,
    K_AXIS_END  = 4'd8
  } kind_t;

  typedef enum logic [1:0] {
    CFG_END_DELAY   = 2'd0,
    CFG_TIMEOUT     = 2'd1,
    CFG_SPEED_LIMIT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    report_t [2:0] code;
    logic    [1:0] count;
    phase_t        phase;
  } entry_t;

endpackage

// File: design/sfr_front.sv
module sfr_front #(
  parameter int unsigned TIMER_BITS = sfr_pkg::TimerBitsDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       acc,
  input  logic [3:0]                 kind,
  input  logic [sfr_pkg::SpeedW-1:0] rel_speed,
  input  logic                       speed_present,
  input  logic                       axis_source,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [sfr_pkg::CfgW-1:0]   cfg_data,
  output sfr_pkg::entry_t            ent
);
  import sfr_pkg::*;

  localparam logic [32:0] TMax = (33'd1 << TIMER_BITS) - 33'd1;

  logic [CfgW-1:0]       end_delay_r, timeout_r, limit_r;
  phase_t                phase_r, phase_nxt;
  logic                  touching_r, touching_nxt;
  logic [TIMER_BITS-1:0] end_cnt_r, end_cnt_nxt, to_cnt_r, to_cnt_nxt;
  logic                  end_armed_r, end_armed_nxt, to_armed_r, to_armed_nxt;
  logic [TIMER_BITS-1:0] end_load, to_load;
  logic [32:0]           end_wide, to_wide;
  logic                  end_fire, to_fire;
  logic [ScaledW-1:0]    speed_ext, speed_scaled;
  logic                  fast;
  report_t [2:0]         code;
  logic [1:0]            count;

  assign end_wide = 33'(end_delay_r);
  assign to_wide  = 33'(timeout_r);
  assign end_load = (end_wide > TMax) ? TMax[TIMER_BITS-1:0] : end_wide[TIMER_BITS-1:0];
  assign to_load  = (to_wide > TMax) ? TMax[TIMER_BITS-1:0] : to_wide[TIMER_BITS-1:0];

  assign end_fire = end_armed_r && (end_cnt_r <= TIMER_BITS'(1));
  assign to_fire  = to_armed_r && (to_cnt_r <= TIMER_BITS'(1));

  assign speed_ext    = ScaledW'(rel_speed);
  assign speed_scaled = axis_source ? ((speed_ext << 3) + (speed_ext << 1)) : speed_ext;
  assign fast         = speed_present && (speed_scaled > ScaledW'(limit_r));

  always_comb begin
    phase_nxt     = phase_r;
    touching_nxt  = touching_r;
    end_cnt_nxt   = end_cnt_r;
    end_armed_nxt = end_armed_r;
    to_cnt_nxt    = to_cnt_r;
    to_armed_nxt  = to_armed_r;
    code          = '{default: RP_NONE};
    count         = 2'd0;
    unique case (kind)
      K_TICK: begin
        if (end_armed_r) begin
          end_cnt_nxt   = end_fire ? '0 : end_cnt_r - TIMER_BITS'(1);
          end_armed_nxt = !end_fire;
        end
        if (to_armed_r) begin
          to_cnt_nxt   = to_fire ? '0 : to_cnt_r - TIMER_BITS'(1);
          to_armed_nxt = !to_fire;
        end
        if ((end_fire || to_fire) && phase_r == PH_FLING) begin
          code[0]   = RP_FLING_OFF;
          code[1]   = RP_DRAW_STOP;
          count     = 2'd2;
          phase_nxt = PH_IDLE;
        end
      end
      K_DETECT: begin
        if (phase_r == PH_FLING) begin
          end_armed_nxt = 1'b0;
          to_armed_nxt  = 1'b0;
          end_cnt_nxt   = '0;
          to_cnt_nxt    = '0;
          code[0]       = RP_FLING_OFF;
          code[1]       = RP_DRAW_STOP;
          code[2]       = RP_DRAW_START;
          count         = 2'd3;
        end else begin
          code[0] = RP_DRAW_START;
          count   = 2'd1;
        end
        phase_nxt = PH_DETECT;
      end
      K_FLING_ON: begin
        if (phase_r != PH_FLING) begin
          code[0]       = RP_DRAW_START;
          count         = 2'd1;
          phase_nxt     = PH_FLING;
          end_cnt_nxt   = end_load;
          end_armed_nxt = 1'b1;
          to_cnt_nxt    = to_load;
          to_armed_nxt  = 1'b1;
        end
      end
      K_SLIDE_OFF: begin
        end_armed_nxt = 1'b0;
        to_armed_nxt  = 1'b0;
        end_cnt_nxt   = '0;
        to_cnt_nxt    = '0;
        code[0]       = RP_DRAW_STOP;
        count         = 2'd1;
        phase_nxt     = PH_IDLE;
      end
      K_FRAME: begin
        if (phase_r == PH_DETECT) begin
          if (touching_r) begin
            code[0]   = RP_SLIDE_BEGIN;
            code[1]   = RP_DRAW_STOP;
            count     = 2'd2;
            phase_nxt = PH_NORMAL;
          end else begin
            code[0]   = RP_DRAW_STOP;
            count     = 2'd1;
            phase_nxt = PH_IDLE;
          end
        end else if (phase_r == PH_FLING) begin
          end_cnt_nxt   = end_load;
          end_armed_nxt = 1'b1;
        end
      end
      K_DOWN: begin
        phase_nxt    = PH_IDLE;
        touching_nxt = 1'b1;
      end
      K_UP, K_PULL_UP, K_AXIS_END: begin
        touching_nxt = 1'b0;
        if (phase_r == PH_NORMAL) begin
          code[0] = RP_SLIDE_END;
          if (fast) begin
            code[1]   = RP_DRAW_START;
            code[2]   = RP_FLING_ON;
            count     = 2'd3;
            phase_nxt = PH_FLING;
          end else begin
            count = 2'd1;
          end
        end else if (phase_r == PH_DETECT && fast) begin
          code[0]   = RP_DRAW_START;
          code[1]   = RP_FLING_ON;
          count     = 2'd2;
          phase_nxt = PH_FLING;
        end
      end
      default: begin
      end
    endcase
    if (count == 2'd0) begin
      code[0] = RP_NONE;
      count   = 2'd1;
    end
  end

  assign ent.code  = code;
  assign ent.count = count;
  assign ent.phase = phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      end_delay_r <= '0;
      timeout_r   <= '0;
      limit_r     <= '0;
      phase_r     <= PH_IDLE;
      touching_r  <= 1'b0;
      end_cnt_r   <= '0;
      end_armed_r <= 1'b0;
      to_cnt_r    <= '0;
      to_armed_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_END_DELAY:   end_delay_r <= cfg_data;
          CFG_TIMEOUT:     timeout_r   <= cfg_data;
          CFG_SPEED_LIMIT: limit_r     <= cfg_data;
          default: begin
          end
        endcase
      end
      if (acc) begin
        phase_r     <= phase_nxt;
        touching_r  <= touching_nxt;
        end_cnt_r   <= end_cnt_nxt;
        end_armed_r <= end_armed_nxt;
        to_cnt_r    <= to_cnt_nxt;
        to_armed_r  <= to_armed_nxt;
      end
    end
  end

  a_slide_off_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == K_SLIDE_OFF |=> !end_armed_r && !to_armed_r && phase_r == PH_IDLE)
    else $error("slide off left a timer armed");

  a_down_touches: assert property (@(posedge clk) disable iff (!rst_n)
    acc && kind == K_DOWN |=> touching_r && phase_r == PH_IDLE)
    else $error("down did not register a touch");

  a_fling_only_from_release: assert property (@(posedge clk) disable iff (!rst_n)
    acc && ent.phase == PH_FLING && phase_r != PH_FLING |->
      kind == K_FLING_ON || kind == K_UP || kind == K_PULL_UP || kind == K_AXIS_END)
    else $error("fling entered from an unexpected event");

endmodule

// File: design/sfr_queue.sv
module sfr_queue #(
  parameter int unsigned DEPTH = sfr_pkg::QueueDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  sfr_pkg::entry_t wdata,
  input  logic            pop,
  output sfr_pkg::entry_t rdata,
  output logic            full,
  output logic            empty
);
  import sfr_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  entry_t            mem [DEPTH];
  logic [PtrW-1:0]   wptr_r, rptr_r;
  logic [CntW-1:0]   cnt_r;
  logic              do_push, do_pop;

  assign full    = (cnt_r == CntW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) begin
        wptr_r <= (wptr_r == PtrW'(DEPTH - 1)) ? '0 : wptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == PtrW'(DEPTH - 1)) ? '0 : rptr_r + PtrW'(1);
      end
      cnt_r <= cnt_r + CntW'(do_push) - CntW'(do_pop);
    end
  end

endmodule

// File: design/sfr_back.sv
module sfr_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sfr_pkg::entry_t q_data,
  input  logic            q_empty,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output logic [2:0]      report,
  output logic [1:0]      phase_after,
  output logic            last
);
  import sfr_pkg::*;

  entry_t     cur_r;
  logic [1:0] idx_r;
  logic       valid_r;
  logic       take;

  assign last        = (idx_r == cur_r.count - 2'd1);
  assign take        = !valid_r || (pop && last);
  assign q_pop       = take && !q_empty;
  assign empty       = !valid_r;
  assign report      = cur_r.code[idx_r];
  assign phase_after = cur_r.phase;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (take) begin
      valid_r <= !q_empty;
      idx_r   <= '0;
    end else if (pop) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !q_empty) begin
      cur_r <= q_data;
    end
  end

  a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && pop && !last |=> valid_r && idx_r == $past(idx_r) + 2'd1)
    else $error("result dropped inside an item");

  a_none_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && report == RP_NONE |-> last && idx_r == 2'd0)
    else $error("empty report not a lone result");

endmodule

// File: design/slide_fling_recognizer.sv
// An accepted item goes into the internal queue and then into the output register
// when free (empty or last result popped), with its first result on the out_ ports.
// Throughput: one item accepted per cycle while the internal queue has room;
// each item leaves as one to three results, one per pop. The result side's pop
// rate sets the sustained pace.
// Reset (synchronous, rst_n low): phase idle, timers disarmed, registers zero,
// queue and output empty.
module slide_fling_recognizer #(
  parameter int unsigned TIMER_BITS  = sfr_pkg::TimerBitsDef,
  parameter int unsigned QUEUE_DEPTH = sfr_pkg::QueueDepthDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  output logic                       full,
  input  logic [3:0]                 in_kind,
  input  logic [sfr_pkg::SpeedW-1:0] in_rel_speed,
  input  logic                       in_speed_present,
  input  logic                       in_axis_source,
  output logic                       empty,
  input  logic                       pop,
  output logic [2:0]                 out_report,
  output logic [1:0]                 out_phase_after,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [sfr_pkg::CfgW-1:0]   cfg_data
);
  import sfr_pkg::*;

  entry_t ent, q_data;
  logic   acc, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign acc       = push && !q_full;

  sfr_front #(.TIMER_BITS(TIMER_BITS)) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .kind          (in_kind),
    .rel_speed     (in_rel_speed),
    .speed_present (in_speed_present),
    .axis_source   (in_axis_source),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .ent           (ent)
  );

  sfr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (acc),
    .wdata (ent),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  sfr_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_data      (q_data),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .report      (out_report),
    .phase_after (out_phase_after),
    .last        (out_last)
  );

endmodule
